@@ rtl/core/multi_waveform_generator_unit_defines.svh @@
// Assertion macros used by the waveform generator checker.
// Standalone header; it depends on nothing else.
`ifndef MULTI_WAVEFORM_GENERATOR_UNIT_DEFINES_SVH
`define MULTI_WAVEFORM_GENERATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MWG_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MWG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/mwg_pkg.sv @@
// Shared types, constants and the sine table builder for the waveform generator.
// No dependencies; mwg_front, mwg_back and the top level import this package.
`default_nettype none

package mwg_pkg;

    // Field widths fixed by the interface.
    localparam int VALUE_W   = 32;
    localparam int OFFSET_W  = 16;
    localparam int DUTY_W    = 17;
    localparam int WAVE_W    = 3;
    localparam int CFG_IDX_W = 3;

    // Unit value (v+1)/2 in units of 1/131072 spans 0..131072.
    localparam int UNIT_W = 18;
    localparam logic [UNIT_W-1:0] UNIT_MID  = 18'd65536;
    localparam logic [UNIT_W-1:0] UNIT_FULL = 18'd131072;
    localparam logic [UNIT_W-1:0] UNIT_TRI  = 18'd196608;
    localparam logic [15:0]       TRI_RISE_END = 16'd16384;
    localparam logic [15:0]       TRI_FALL_END = 16'd49151;

    // Quarter-wave sine table; the depth is a power of two.
    localparam int SINE_DEPTH = 256;
    localparam int SINE_AW    = $clog2(SINE_DEPTH);
    localparam int SINE_W     = 17;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Queue depths and their count widths.
    localparam int MID_DEPTH = 4;
    localparam int MID_CW    = $clog2(MID_DEPTH + 1);
    localparam int OUT_DEPTH = 4;
    localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_TYPE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELTA_MODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQUENCY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEVEL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CYCLE   = 3'd6;

    // Waveform selection codes.
    localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd0;
    localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd1;
    localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 3'd2;
    localparam logic [WAVE_W-1:0] WAVE_SAW      = 3'd3;
    localparam logic [WAVE_W-1:0] WAVE_INV_SAW  = 3'd4;
    localparam logic [WAVE_W-1:0] WAVE_PWM      = 3'd5;

    typedef logic [SINE_W-1:0] t_sine_word;
    typedef t_sine_word t_sine_rom [SINE_DEPTH+1];

    // Settings used by the phase front end.
    typedef struct packed {
        logic                       delta_mode;
        logic signed [VALUE_W-1:0]  frequency;
        logic [OFFSET_W-1:0]        phase_offset;
    } t_front_cfg;

    // Settings used by the waveform back end.
    typedef struct packed {
        logic [WAVE_W-1:0]          wave_type;
        logic signed [VALUE_W-1:0]  base_level;
        logic signed [VALUE_W-1:0]  amplitude;
        logic [DUTY_W-1:0]          duty_cycle;
    } t_back_cfg;

    // Builds the quarter-wave table at elaboration with a Q30 Taylor series.
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] e;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            x  = (64'(k) * HALF_PI_Q30) / 64'(SINE_DEPTH);
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
            s  = (x * t) >> 30;
            e  = (s + 64'd8192) >> 14;
            rom[k] = (e > 64'd65536) ? 17'd65536 : e[SINE_W-1:0];
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/multi_waveform_generator_unit.sv @@
// Throughput: one request per cycle while full stays low; the 32x32 phase multiplier and the
// amplitude multiplier are each one pipeline stage, and small queues absorb stalls.
// Reset (synchronous, active low) restores the register defaults, clears the phase
// accumulator and empties both queues; requests are taken right after reset.
// Top level: configuration registers, front end, middle queue, back end, output queue.
// Depends on mwg_pkg, mwg_front, mwg_back and mwg_fifo.
`default_nettype none

module multi_waveform_generator_unit import mwg_pkg::*; #(
    parameter int PHASE_BITS = 16,
    parameter int DATA_BITS  = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic signed [VALUE_W-1:0]   i_source_time,
    output logic                        empty,
    input  logic                        pop,
    output logic signed [VALUE_W-1:0]   o_wave_value,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [VALUE_W-1:0]          i_cfg_data
);

    logic [WAVE_W-1:0]          r_wave_type;
    logic                       r_delta_mode;
    logic signed [VALUE_W-1:0]  r_frequency;
    logic [OFFSET_W-1:0]        r_phase_offset;
    logic signed [VALUE_W-1:0]  r_base_level;
    logic signed [VALUE_W-1:0]  r_amplitude;
    logic [DUTY_W-1:0]          r_duty_cycle;

    t_front_cfg                 front_cfg;
    t_back_cfg                  back_cfg;
    logic [MID_CW-1:0]          mid_count;
    logic                       mid_push;
    logic                       mid_pop;
    logic [PHASE_BITS-1:0]      mid_phase_in;
    logic [PHASE_BITS-1:0]      mid_phase_out;
    logic [OUT_CW-1:0]          out_count;
    logic                       out_push;
    logic                       out_pop;
    logic [VALUE_W-1:0]         out_data_in;
    logic [VALUE_W-1:0]         out_data_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_type    <= WAVE_SINE;
            r_delta_mode   <= 1'b0;
            r_frequency    <= 32'sd65536;
            r_phase_offset <= '0;
            r_base_level   <= '0;
            r_amplitude    <= 32'sd65536;
            r_duty_cycle   <= 17'd32768;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WAVE_TYPE:    r_wave_type    <= i_cfg_data[WAVE_W-1:0];
                CFG_DELTA_MODE:   r_delta_mode   <= i_cfg_data[0];
                CFG_FREQUENCY:    r_frequency    <= i_cfg_data;
                CFG_PHASE_OFFSET: r_phase_offset <= i_cfg_data[OFFSET_W-1:0];
                CFG_BASE_LEVEL:   r_base_level   <= i_cfg_data;
                CFG_AMPLITUDE:    r_amplitude    <= i_cfg_data;
                CFG_DUTY_CYCLE:   r_duty_cycle   <= i_cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    assign front_cfg = '{delta_mode:   r_delta_mode,
                         frequency:    r_frequency,
                         phase_offset: r_phase_offset};
    assign back_cfg  = '{wave_type:    r_wave_type,
                         base_level:   r_base_level,
                         amplitude:    r_amplitude,
                         duty_cycle:   r_duty_cycle};

    // Phase front end.
    mwg_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_source_time (i_source_time),
        .i_cfg         (front_cfg),
        .i_mid_count   (mid_count),
        .o_mid_push    (mid_push),
        .o_mid_phase   (mid_phase_in)
    );

    // Queue of phases between the two halves.
    mwg_fifo #(
        .WIDTH (PHASE_BITS),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_phase_in),
        .i_pop   (mid_pop),
        .o_data  (mid_phase_out),
        .o_count (mid_count)
    );

    // Waveform back end.
    mwg_back #(
        .PHASE_BITS (PHASE_BITS),
        .DATA_BITS  (DATA_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (back_cfg),
        .i_mid_count (mid_count),
        .i_mid_phase (mid_phase_out),
        .o_mid_pop   (mid_pop),
        .i_out_count (out_count),
        .o_out_push  (out_push),
        .o_out_data  (out_data_in)
    );

    // Result queue toward the consumer.
    mwg_fifo #(
        .WIDTH (VALUE_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_data_in),
        .i_pop   (out_pop),
        .o_data  (out_data_out),
        .o_count (out_count)
    );

    assign empty        = (out_count == '0);
    assign out_pop      = pop && !empty;
    assign o_wave_value = out_data_out;

endmodule

`default_nettype wire

@@ rtl/core/mwg_fifo.sv @@
// Small register-based queue used between the front end and back end and at the output.
// Depends on nothing; the caller never pushes when full or pops when empty.
`default_nettype none

module mwg_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  logic [WIDTH-1:0]                 i_data,
    input  logic                             i_pop,
    output logic [WIDTH-1:0]                 o_data,
    output logic [$clog2(DEPTH+1)-1:0]       o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] ptr);
        return (ptr == AW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

`default_nettype wire

@@ rtl/core/mwg_front.sv @@
// Front end: accepts time requests, multiplies by the frequency and forms the phase.
// Depends on mwg_pkg; feeds the middle queue.
`default_nettype none

module mwg_front import mwg_pkg::*; #(
    parameter int PHASE_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic signed [VALUE_W-1:0]   i_source_time,
    input  t_front_cfg                  i_cfg,
    input  logic [MID_CW-1:0]           i_mid_count,
    output logic                        o_mid_push,
    output logic [PHASE_BITS-1:0]       o_mid_phase
);

    logic                         accept;
    logic [MID_CW:0]              in_flight;
    logic [VALUE_W-1:0]           full_prod;
    logic                         r_prod_valid;
    logic [VALUE_W-1:0]           r_prod;
    logic [PHASE_BITS-1:0]        r_acc;
    logic [PHASE_BITS-1:0]        raw_phase;
    logic [PHASE_BITS-1:0]        off_phase;
    logic [PHASE_BITS-1:0]        acc_sum;
    logic [OFFSET_W+VALUE_W-1:0]  off_wide;

    // Hold off requests while the queue could not absorb everything in flight.
    assign in_flight = {1'b0, i_mid_count} + (MID_CW+1)'(r_prod_valid);
    assign o_full    = in_flight >= (MID_CW+1)'(MID_DEPTH);
    assign accept    = i_push && !o_full;

    // Only the fractional word of the product matters for the phase.
    assign full_prod = i_source_time * i_cfg.frequency;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod <= full_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else begin
            r_prod_valid <= accept;
        end
    end

    // Phase from the top fraction bits, offset aligned to the phase width.
    assign raw_phase = r_prod[VALUE_W-1 -: PHASE_BITS];
    assign off_wide  = {i_cfg.phase_offset, {VALUE_W{1'b0}}};
    assign off_phase = off_wide[OFFSET_W+VALUE_W-1 -: PHASE_BITS];
    assign acc_sum   = r_acc + raw_phase;

    // The accumulator only moves in delta mode.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (r_prod_valid && i_cfg.delta_mode) begin
            r_acc <= acc_sum;
        end
    end

    assign o_mid_push  = r_prod_valid;
    assign o_mid_phase = i_cfg.delta_mode ? (acc_sum + off_phase) : (raw_phase + off_phase);

endmodule

`default_nettype wire

@@ rtl/core/mwg_back.sv @@
// Back end: shapes the waveform from the phase, scales by amplitude and saturates.
// Depends on mwg_pkg; reads the middle queue and writes the output queue.
`default_nettype none

module mwg_back import mwg_pkg::*; #(
    parameter int PHASE_BITS = 16,
    parameter int DATA_BITS  = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_back_cfg               i_cfg,
    input  logic [MID_CW-1:0]       i_mid_count,
    input  logic [PHASE_BITS-1:0]   i_mid_phase,
    output logic                    o_mid_pop,
    input  logic [OUT_CW-1:0]       i_out_count,
    output logic                    o_out_push,
    output logic [VALUE_W-1:0]      o_out_data
);

    localparam int PROD_W = UNIT_W + 1 + VALUE_W;
    localparam t_sine_rom SINE_ROM = build_sine_rom();
    localparam logic [PHASE_BITS-2:0] QUARTER = {1'b1, {(PHASE_BITS-2){1'b0}}};
    localparam logic [PHASE_BITS-1:0] HALF    = {1'b1, {(PHASE_BITS-1){1'b0}}};
    localparam logic signed [PROD_W-1:0] SAT_HI =
        PROD_W'((longint'(1) <<< (DATA_BITS - 1)) - longint'(1));
    localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(65536);

    logic [OUT_CW:0]                 load;
    logic                            issue;
    logic [PHASE_BITS+15:0]          p_wide;
    logic [15:0]                     p16;
    logic [1:0]                      quadrant;
    logic [PHASE_BITS-2:0]           frac;
    logic [PHASE_BITS-2:0]           fpos;
    logic [PHASE_BITS+SINE_AW-2:0]   f_scaled;
    logic [SINE_AW:0]                sine_idx;
    logic [SINE_W-1:0]               sine_word;
    logic [UNIT_W-1:0]               p16_x4;
    logic [UNIT_W-1:0]               saw;
    logic [UNIT_W-1:0]               unit;
    logic [PHASE_BITS+16:0]          pwm_phase;
    logic [PHASE_BITS+16:0]          pwm_duty;
    logic                            r_v1;
    logic                            r_v2;
    logic [UNIT_W-1:0]               r_unit;
    logic signed [PROD_W-1:0]        r_prod;
    logic signed [PROD_W-1:0]        rnd_sum;
    logic signed [PROD_W-1:0]        scaled;
    logic signed [PROD_W-1:0]        res;
    logic signed [PROD_W-1:0]        res_sat;

    // Issue a phase only when the output queue has room for all items in flight.
    assign load      = (OUT_CW+1)'(i_out_count) + (OUT_CW+1)'(r_v1) + (OUT_CW+1)'(r_v2);
    assign issue     = (i_mid_count != '0) && (load < (OUT_CW+1)'(OUT_DEPTH));
    assign o_mid_pop = issue;

    // Phase as a 16-bit fraction and quarter-wave addressing.
    assign p_wide    = {i_mid_phase, 16'd0};
    assign p16       = p_wide[PHASE_BITS+15 -: 16];
    assign quadrant  = i_mid_phase[PHASE_BITS-1 -: 2];
    assign frac      = {1'b0, i_mid_phase[PHASE_BITS-3:0]};
    assign fpos      = quadrant[0] ? (QUARTER - frac) : frac;
    assign f_scaled  = {fpos, {SINE_AW{1'b0}}};
    assign sine_idx  = f_scaled[PHASE_BITS+SINE_AW-2 -: SINE_AW+1];
    assign sine_word = SINE_ROM[sine_idx];

    assign p16_x4    = {p16, 2'b00};
    assign saw       = {1'b0, p16, 1'b0};
    assign pwm_phase = {1'b0, i_mid_phase, 16'd0};
    assign pwm_duty  = {i_cfg.duty_cycle, {PHASE_BITS{1'b0}}};

    // Unit value of the selected waveform.
    always_comb begin
        case (i_cfg.wave_type)
            WAVE_SINE: begin
                unit = quadrant[1] ? (UNIT_MID - UNIT_W'(sine_word))
                                   : (UNIT_MID + UNIT_W'(sine_word));
            end
            WAVE_TRIANGLE: begin
                if (p16 < TRI_RISE_END) begin
                    unit = p16_x4 + UNIT_MID;
                end else if (p16 inside {[TRI_RISE_END:TRI_FALL_END]}) begin
                    unit = UNIT_TRI - p16_x4;
                end else begin
                    unit = p16_x4 - UNIT_TRI;
                end
            end
            WAVE_SQUARE:  unit = (i_mid_phase <= HALF) ? UNIT_FULL : '0;
            WAVE_SAW:     unit = saw;
            WAVE_INV_SAW: unit = UNIT_FULL - saw;
            WAVE_PWM:     unit = (pwm_phase <= pwm_duty) ? UNIT_FULL : '0;
            default:      unit = UNIT_MID;
        endcase
    end

    // Stage one holds the unit value, stage two the amplitude product.
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_unit <= unit;
        end
        if (r_v1) begin
            r_prod <= PROD_W'(signed'({1'b0, r_unit})) * PROD_W'(i_cfg.amplitude);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
        end
    end

    // Round half up, add the base level and clamp to the data range.
    assign rnd_sum = r_prod + ROUND_HALF;
    assign scaled  = rnd_sum >>> 17;
    assign res     = PROD_W'(i_cfg.base_level) + scaled;

    always_comb begin
        if (res > SAT_HI) begin
            res_sat = SAT_HI;
        end else if (res < SAT_LO) begin
            res_sat = SAT_LO;
        end else begin
            res_sat = res;
        end
    end

    assign o_out_push = r_v2;
    assign o_out_data = res_sat[VALUE_W-1:0];

endmodule

`default_nettype wire

@@ rtl/core/mwg_checker.sv @@
// Port-level checker for the waveform generator and its bind to the top level.
// Depends on multi_waveform_generator_unit_defines.svh for the assertion macros.
`default_nettype none

`include "multi_waveform_generator_unit_defines.svh"

module mwg_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        empty,
    input  logic        pop,
    input  logic [31:0] o_wave_value
);

    logic [4:0] r_pending;
    logic       req_taken;
    logic       res_taken;

    assign req_taken = push && !full;
    assign res_taken = pop && !empty;

    // Requests accepted but whose results have not yet been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            case ({req_taken, res_taken})
                2'b10:   r_pending <= r_pending + 1'b1;
                2'b01:   r_pending <= r_pending - 1'b1;
                default: r_pending <= r_pending;
            endcase
        end
    end

    // A result may only appear for a request that was accepted.
    `MWG_ASSERT_SAME(a_no_phantom, i_clk, i_rst_n, !empty, r_pending != 5'd0, "no request")
    // Backpressure is only applied while requests are outstanding.
    `MWG_ASSERT_SAME(a_full_busy, i_clk, i_rst_n, full, r_pending != 5'd0, "full while idle")
    // A waiting result is not withdrawn.
    `MWG_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, !empty && !pop, !empty, "result dropped")
    // A waiting result keeps its value.
    `MWG_ASSERT_NEXT(a_value_held, i_clk, i_rst_n, !empty && !pop, $stable(o_wave_value), "changed")

endmodule

bind multi_waveform_generator_unit mwg_checker u_mwg_checker (.*);

`default_nettype wire
